@@ rtl/core/sipf_pkg.sv @@
// Shared types and constants for the SI prefix value formatter.
// Holds the configuration struct, the front-to-back record and character codes.
// No dependencies.
`default_nettype none

package sipf_pkg;

  // Decimal digits carried from front to back (two to seven significant digits)
  localparam int REC_DIGITS = 7;

  // Character codes
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_LONG_FORMAT = 2'd0,
    CFG_SKIP_NANO   = 2'd1,
    CFG_SHOW_SIGN   = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic long_format;
    logic skip_nano;
    logic show_sign;
  } cfg_t;

  // One formatted value, ready for serialisation
  typedef struct packed {
    logic                           sign_en;
    logic [7:0]                     sign_ch;
    logic                           lead_dot;
    logic [REC_DIGITS-1:0][3:0]     digs;     // BCD, least significant first
    logic [2:0]                     len;      // significant digits
    logic [3:0]                     total;    // digits incl. padding zeros
    logic                           has_pt;   // inner decimal point present
    logic [3:0]                     off;      // point follows digit at this countdown
    logic [7:0]                     prefix;   // zero means none
    logic [7:0]                     unit;     // zero means none
  } fmt_rec_t;

  // SI prefix letter for a prefix index, femto upwards
  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h66;  // f
      4'd1:    ch = 8'h70;  // p
      4'd2:    ch = 8'h6e;  // n
      4'd3:    ch = 8'h75;  // u
      4'd4:    ch = 8'h6d;  // m
      4'd6:    ch = 8'h6b;  // k
      4'd7:    ch = 8'h4d;  // M
      default: ch = 8'h00;  // unity and beyond mega
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/sipf_front.sv @@
// Front end of the formatter: takes a value, converts it to BCD, rounds it to
// the digit limit and works out prefix, point place and padding.
// Depends on sipf_pkg.
`default_nettype none

module sipf_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  sipf_pkg::cfg_t         cfg,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic signed [4:0]      exponent,
  input  logic [7:0]             unit_char,
  input  logic [3:0]             digit_count,
  input  logic                   leading_zeros,
  input  logic                   force_plus,
  output logic                   busy,
  output logic                   push,
  output sipf_pkg::fmt_rec_t     push_rec,
  input  logic                   q_full
);
  import sipf_pkg::*;

  localparam int PAD_W      = ((VALUE_WIDTH + 3) / 4) * 4;
  localparam int CONV_STEPS = PAD_W / 4;
  localparam int CNT_W      = $clog2(CONV_STEPS);
  localparam int NUM_DIG    = (VALUE_WIDTH * 301) / 1000 + 1;
  localparam int NDIG_W     = $clog2(NUM_DIG + 1);
  localparam int EXT_DIG    = (NUM_DIG > REC_DIGITS) ? NUM_DIG : REC_DIGITS;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CONV_STEPS - 1);

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_ROUND,
    F_PUSH
  } fstate_t;

  fstate_t                 fstate;
  logic [PAD_W-1:0]        sh;
  logic [NUM_DIG*4-1:0]    bcd;
  logic [CNT_W-1:0]        cnt;
  logic signed [5:0]       exp_r;
  logic [2:0]              lim;
  logic [7:0]              unit_r;
  logic [3:0]              dcnt_r;
  logic                    lz_r;
  logic                    sign_en_r;
  logic [7:0]              sign_ch_r;
  logic [3:0]              idx0;
  logic [1:0]              off0;
  logic [2:0]              len_r;

  logic                    neg;
  logic [VALUE_WIDTH-1:0]  mag;
  logic [2:0]              lim_next;
  logic [NUM_DIG*4-1:0]    bcd_conv;
  logic [PAD_W-1:0]        sh_conv;
  logic [NDIG_W-1:0]       ndig;
  logic [NUM_DIG*4-1:0]    rnd;
  logic                    carry;
  logic [5:0]              e17;
  logic [11:0]             prod;
  logic [3:0]              quo;
  logic [5:0]              rem6;

  // Sign, magnitude and digit limit at the transfer
  always_comb begin
    neg = cfg.show_sign && value[VALUE_WIDTH-1];
    mag = neg ? (~value + VALUE_WIDTH'(1)) : value;
    unique case (digit_count)
      4'd3:    lim_next = 3'd3;
      4'd4:    lim_next = 3'd4;
      4'd5:    lim_next = cfg.long_format ? 3'd5 : 3'd2;
      4'd6:    lim_next = cfg.long_format ? 3'd6 : 3'd2;
      4'd7:    lim_next = cfg.long_format ? 3'd7 : 3'd2;
      default: lim_next = 3'd2;
    endcase
  end

  // Double dabble, four bits a cycle
  always_comb begin
    bcd_conv = bcd;
    sh_conv  = sh;
    for (int b = 0; b < 4; b++) begin
      for (int i = 0; i < NUM_DIG; i++) begin
        if (bcd_conv[i*4 +: 4] >= 4'd5) begin
          bcd_conv[i*4 +: 4] = bcd_conv[i*4 +: 4] + 4'd3;
        end
      end
      bcd_conv = {bcd_conv[NUM_DIG*4-2:0], sh_conv[PAD_W-1]};
      sh_conv  = {sh_conv[PAD_W-2:0], 1'b0};
    end
  end

  // Digit count and one round-half-up step by ten
  always_comb begin
    ndig = NDIG_W'(1);
    for (int i = 0; i < NUM_DIG; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) begin
        ndig = NDIG_W'(i + 1);
      end
    end
    rnd   = {4'd0, bcd[NUM_DIG*4-1:4]};
    carry = (bcd[3:0] >= 4'd5);
    for (int i = 0; i < NUM_DIG; i++) begin
      if (carry) begin
        if (rnd[i*4 +: 4] == 4'd9) begin
          rnd[i*4 +: 4] = 4'd0;
        end else begin
          rnd[i*4 +: 4] = rnd[i*4 +: 4] + 4'd1;
          carry = 1'b0;
        end
      end
    end
  end

  // Prefix index and point offset: (exp + 17) / 3 by reciprocal
  always_comb begin
    e17  = exp_r + 6'd17;
    prod = 12'(e17) * 12'd43;
    quo  = prod[10:7];
    rem6 = e17 - 6'(quo) * 6'd3;
  end

  // Final placement: prefix shift, padding and decimal point
  logic [3:0]        idx_a;
  logic [3:0]        off_a;
  logic [3:0]        pad_diff;
  logic [2:0]        rsh0;
  logic [2:0]        rsh;
  logic signed [5:0] pos;
  logic              lead;
  logic [3:0]        lead_diff;
  logic [EXT_DIG*4-1:0] bcd_ext;

  always_comb begin
    idx_a = idx0;
    off_a = {2'b00, off0};
    if (cfg.long_format && (5'(len_r) > 5'(off_a) + 5'd4) &&
        (!cfg.skip_nano || idx_a != 4'd0)) begin
      idx_a = idx_a + 4'd1;
      off_a = off_a + 4'd3;
    end
    if (cfg.skip_nano && idx_a == 4'd2) begin
      idx_a = idx_a + 4'd1;
      off_a = off_a + 4'd3;
    end

    pad_diff = dcnt_r - 4'(len_r);
    if (lz_r && dcnt_r > 4'(len_r)) begin
      rsh0 = (pad_diff > 4'd6) ? 3'd6 : pad_diff[2:0];
    end else begin
      rsh0 = 3'd0;
    end

    pos       = $signed(6'(len_r) + 6'(rsh0) - 6'(off_a));
    lead      = (pos <= 6'sd0);
    lead_diff = off_a - 4'(len_r);
    if (lead) begin
      if (off_a <= 4'(len_r)) rsh = 3'd0;
      else rsh = (lead_diff > 4'd6) ? 3'd6 : lead_diff[2:0];
    end else begin
      rsh = rsh0;
    end

    bcd_ext = (EXT_DIG*4)'(bcd);

    push_rec.sign_en  = sign_en_r;
    push_rec.sign_ch  = sign_ch_r;
    push_rec.lead_dot = lead;
    push_rec.digs     = bcd_ext[REC_DIGITS*4-1:0];
    push_rec.len      = len_r;
    push_rec.total    = 4'(len_r) + 4'(rsh);
    push_rec.has_pt   = !lead && (off_a != 4'd0);
    push_rec.off      = off_a;
    push_rec.prefix   = prefix_char(idx_a);
    push_rec.unit     = unit_r;
  end

  assign busy = (fstate != F_IDLE);
  assign push = (fstate == F_PUSH) && !q_full;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      fstate <= F_IDLE;
    end else begin
      unique case (fstate)
        F_IDLE: begin
          if (start) begin
            sh        <= PAD_W'(mag);
            bcd       <= '0;
            cnt       <= '0;
            exp_r     <= {exponent[4], exponent};
            lim       <= lim_next;
            unit_r    <= unit_char;
            dcnt_r    <= digit_count;
            lz_r      <= leading_zeros;
            sign_en_r <= neg || (cfg.show_sign && force_plus);
            sign_ch_r <= neg ? CH_MINUS : CH_PLUS;
            fstate    <= F_CONV;
          end
        end
        F_CONV: begin
          bcd <= bcd_conv;
          sh  <= sh_conv;
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_LAST) fstate <= F_ROUND;
        end
        F_ROUND: begin
          if (ndig > NDIG_W'(lim)) begin
            bcd   <= rnd;
            exp_r <= exp_r + 6'sd1;
          end else begin
            idx0   <= quo;
            off0   <= 2'd2 - rem6[1:0];
            len_r  <= 3'(ndig);
            fstate <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) fstate <= F_IDLE;
        end
        default: fstate <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sipf_queue.sv @@
// Two-entry queue of formatted records between front and back ends.
// Depends on sipf_pkg.
`default_nettype none

module sipf_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sipf_pkg::fmt_rec_t push_rec,
  output logic               full,
  input  logic               pop,
  output sipf_pkg::fmt_rec_t pop_rec,
  output logic               empty
);
  import sipf_pkg::*;

  fmt_rec_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign pop_rec = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_rec;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sipf_back.sv @@
// Back end of the formatter: serialises one record as characters, one a cycle.
// Depends on sipf_pkg.
`default_nettype none

module sipf_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  sipf_pkg::fmt_rec_t q_rec,
  output logic               pop,
  output logic               char_strobe,
  output logic [7:0]         char_code,
  output logic               last_char
);
  import sipf_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SIGN,
    B_DOT,
    B_DIG,
    B_PT,
    B_PRE,
    B_UNIT
  } bstate_t;

  bstate_t    bstate;
  fmt_rec_t   rec;
  logic [3:0] k;        // digit countdown, zero is the last digit
  logic [7:0] dig_ch;
  logic       no_tail;

  assign pop     = (bstate == B_IDLE) && !q_empty;
  assign no_tail = (rec.prefix == 8'h00) && (rec.unit == 8'h00);

  // Digit character: a significant digit, or a padding zero above the significant digits
  always_comb begin
    if (k < 4'(rec.len)) dig_ch = CH_ZERO + 8'(rec.digs[k[2:0]]);
    else dig_ch = CH_ZERO;
  end

  // Character sequencer with registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      bstate      <= B_IDLE;
      char_strobe <= 1'b0;
      last_char   <= 1'b0;
    end else begin
      char_strobe <= 1'b0;
      last_char   <= 1'b0;
      unique case (bstate)
        B_IDLE: begin
          if (!q_empty) begin
            rec <= q_rec;
            k   <= q_rec.total - 4'd1;
            if (q_rec.sign_en) bstate <= B_SIGN;
            else if (q_rec.lead_dot) bstate <= B_DOT;
            else bstate <= B_DIG;
          end
        end
        B_SIGN: begin
          char_strobe <= 1'b1;
          char_code   <= rec.sign_ch;
          bstate      <= rec.lead_dot ? B_DOT : B_DIG;
        end
        B_DOT: begin
          char_strobe <= 1'b1;
          char_code   <= CH_DOT;
          bstate      <= B_DIG;
        end
        B_DIG: begin
          char_strobe <= 1'b1;
          char_code   <= dig_ch;
          last_char   <= (k == 4'd0) && no_tail;
          if (k == 4'd0) begin
            if (rec.prefix != 8'h00) bstate <= B_PRE;
            else if (rec.unit != 8'h00) bstate <= B_UNIT;
            else bstate <= B_IDLE;
          end else begin
            k      <= k - 4'd1;
            bstate <= (rec.has_pt && k == rec.off) ? B_PT : B_DIG;
          end
        end
        B_PT: begin
          char_strobe <= 1'b1;
          char_code   <= CH_DOT;
          bstate      <= B_DIG;
        end
        B_PRE: begin
          char_strobe <= 1'b1;
          char_code   <= rec.prefix;
          last_char   <= (rec.unit == 8'h00);
          bstate      <= (rec.unit != 8'h00) ? B_UNIT : B_IDLE;
        end
        B_UNIT: begin
          char_strobe <= 1'b1;
          char_code   <= rec.unit;
          last_char   <= 1'b1;
          bstate      <= B_IDLE;
        end
        default: bstate <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/si_prefix_value_formatter.sv @@
// Top level of the SI prefix value formatter: configuration registers, front
// end, record queue and character back end.
// Depends on sipf_pkg, sipf_front, sipf_queue and sipf_back.
//
//   channel   signals                                         transfer when
//   -------   ---------------------------------------------   -----------------
//   input     value exponent unit_char digit_count            start && !busy
//             leading_zeros force_plus
//   output    char_code last_char                             char_strobe
//   config    cfg_index cfg_wr_data                           cfg_wr_en
//
// In the front end a value goes through BCD conversion, then as many rounding steps
// by ten as the digit limit needs, then the push into the record queue.
// The back end emits one character a cycle, and none while it loads the next record.
// A two-record queue lets the front end take the next value while characters go out.
// Reset is synchronous and active high; registers return to long_format = 1,
// skip_nano = 0, show_sign = 1. Characters cannot be held off by the receiver.
`default_nettype none

module si_prefix_value_formatter #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic signed [4:0]      exponent,
  input  logic [7:0]             unit_char,
  input  logic [3:0]             digit_count,
  input  logic                   leading_zeros,
  input  logic                   force_plus,
  output logic                   char_strobe,
  output logic [7:0]             char_code,
  output logic                   last_char,
  input  logic                   cfg_wr_en,
  input  logic [1:0]             cfg_index,
  input  logic                   cfg_wr_data
);
  import sipf_pkg::*;

  cfg_t     cfg;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;
  fmt_rec_t push_rec;
  fmt_rec_t pop_rec;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_format <= 1'b1;
      cfg.skip_nano   <= 1'b0;
      cfg.show_sign   <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_LONG_FORMAT: cfg.long_format <= cfg_wr_data;
        CFG_SKIP_NANO:   cfg.skip_nano   <= cfg_wr_data;
        CFG_SHOW_SIGN:   cfg.show_sign   <= cfg_wr_data;
        default:         cfg             <= cfg;
      endcase
    end
  end

  sipf_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .start         (start),
    .value         (value),
    .exponent      (exponent),
    .unit_char     (unit_char),
    .digit_count   (digit_count),
    .leading_zeros (leading_zeros),
    .force_plus    (force_plus),
    .busy          (busy),
    .push          (push),
    .push_rec      (push_rec),
    .q_full        (q_full)
  );

  sipf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .empty    (q_empty)
  );

  sipf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_rec       (pop_rec),
    .pop         (pop),
    .char_strobe (char_strobe),
    .char_code   (char_code),
    .last_char   (last_char)
  );

endmodule

`default_nettype wire

@@ rtl/core/sipf_checker.sv @@
// Port-level checks for the SI prefix value formatter, bound to the top level.
// No package dependencies.
`default_nettype none

module sipf_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic char_strobe,
  input logic last_char
);

  // Reset leaves the block idle and silent
  a_reset_quiet: assert property (@(posedge clk) rst |=> (!busy && !char_strobe))
    else $error("block not idle after reset");

  // A value transfer makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after transfer");

  // The end-of-value mark only travels with a character
  a_last_strobe: assert property (@(posedge clk) disable iff (rst)
    last_char |-> char_strobe)
    else $error("last_char without char_strobe");

  // Back end reloads between values, so no character directly follows the last one
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (char_strobe && last_char) |=> !char_strobe)
    else $error("character right after end of value");

endmodule

bind si_prefix_value_formatter sipf_checker u_sipf_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .char_strobe (char_strobe),
  .last_char   (last_char)
);

`default_nettype wire
